// ----- src/tlnvf_pkg.sv -----
`timescale 1ns / 1ps

package tlnvf_pkg;

	localparam int NUMBER_DIGITS = 6;
	localparam int BCD_W = 4 * NUMBER_DIGITS;
	localparam int DIG_IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [DIG_IDX_W-1:0] dig_idx_t;
	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [QCNT_W-1:0] qcnt_t;

	localparam cfg_idx_t CFG_NUMBER_ALL       = 3'd0;
	localparam cfg_idx_t CFG_NUMBER_NONBLANK  = 3'd1;
	localparam cfg_idx_t CFG_SQUEEZE_BLANK    = 3'd2;
	localparam cfg_idx_t CFG_SHOW_ENDS        = 3'd3;
	localparam cfg_idx_t CFG_SHOW_TABS        = 3'd4;
	localparam cfg_idx_t CFG_SHOW_NONPRINTING = 3'd5;

	localparam dig_idx_t DIG_MAX = dig_idx_t'(NUMBER_DIGITS - 1);
	localparam qptr_t QPTR_MAX = qptr_t'(QUEUE_DEPTH - 1);
	localparam qcnt_t QCNT_FULL = qcnt_t'(QUEUE_DEPTH);

	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_NL     = 8'd10;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_DOLLAR = 8'd36;
	localparam logic [7:0] CH_DASH   = 8'd45;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_QMARK  = 8'd63;
	localparam logic [7:0] CH_UPPER_I = 8'd73;
	localparam logic [7:0] CH_UPPER_M = 8'd77;
	localparam logic [7:0] CH_CARET  = 8'd94;
	localparam logic [7:0] CH_DEL    = 8'd127;
	localparam logic [7:0] CH_CTRL_LIMIT = 8'd32;
	localparam logic [7:0] CH_CTRL_OFFSET = 8'd64;

	typedef struct packed {
		logic number_all;
		logic number_nonblank;
		logic squeeze_blank;
		logic show_ends;
		logic show_tabs;
		logic show_nonprinting;
	} cfg_t;

	// one classified input byte, ready to be expanded by the back end
	typedef struct packed {
		logic             number;
		logic [BCD_W-1:0] bcd;
		logic             dollar;
		logic             meta;
		logic             caret;
		logic [7:0]       ch;
	} item_desc_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_DIGIT,
		PH_TAB,
		PH_DOLLAR,
		PH_META,
		PH_DASH,
		PH_CARET,
		PH_CHAR
	} phase_t;

endpackage

// ----- src/tlnvf_front.sv -----
`timescale 1ns / 1ps

module tlnvf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  tlnvf_pkg::cfg_idx_t   cfg_index,
	input  logic                  cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            byte_in,
	input  logic                  q_full,
	output logic                  push,
	output tlnvf_pkg::item_desc_t push_desc
);

	tlnvf_pkg::cfg_t cfg_q;
	logic after_nl_q;
	logic [1:0] blank_run_q;
	logic [tlnvf_pkg::BCD_W-1:0] bcd_q;

	logic accept;
	logic is_nl;
	logic [1:0] blank_run_next;
	logic drop;
	logic numb;
	logic tab_caret;
	logic np;
	logic meta;
	logic [7:0] c7;
	logic ctrl_caret;
	logic [tlnvf_pkg::BCD_W-1:0] bcd_inc;

	// saturating bcd increment
	function automatic logic [tlnvf_pkg::BCD_W-1:0] bcd_count_up(
		input logic [tlnvf_pkg::BCD_W-1:0] v
	);
		logic [tlnvf_pkg::BCD_W-1:0] r;
		logic carry;
		r = v;
		carry = 1'b1;
		for (int i = 0; i < tlnvf_pkg::NUMBER_DIGITS; i++) begin
			if (carry) begin
				if (v[4*i +: 4] == 4'd9) begin
					r[4*i +: 4] = 4'd0;
				end else begin
					r[4*i +: 4] = v[4*i +: 4] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		return carry ? v : r;
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	assign is_nl = (byte_in == tlnvf_pkg::CH_NL);
	assign blank_run_next = (is_nl && after_nl_q) ?
		((blank_run_q == 2'd2) ? 2'd2 : blank_run_q + 2'd1) : 2'd0;
	assign drop = cfg_q.squeeze_blank && (blank_run_next == 2'd2);

	assign numb = after_nl_q &&
		((cfg_q.number_all && !cfg_q.number_nonblank) || (cfg_q.number_nonblank && !is_nl));
	assign bcd_inc = bcd_count_up(bcd_q);

	assign tab_caret = cfg_q.show_tabs && (byte_in == tlnvf_pkg::CH_TAB);
	assign np = cfg_q.show_nonprinting && (byte_in != tlnvf_pkg::CH_TAB) && !is_nl;
	assign meta = np && byte_in[7];
	assign c7 = meta ? {1'b0, byte_in[6:0]} : byte_in;
	assign ctrl_caret = np && ((c7 < tlnvf_pkg::CH_CTRL_LIMIT) || (c7 == tlnvf_pkg::CH_DEL));

	assign push = accept && !drop;

	always_comb begin
		push_desc.number = numb;
		push_desc.bcd = numb ? bcd_inc : bcd_q;
		push_desc.dollar = cfg_q.show_ends && is_nl;
		push_desc.meta = meta;
		push_desc.caret = tab_caret || ctrl_caret;
		if (tab_caret) begin
			push_desc.ch = tlnvf_pkg::CH_UPPER_I;
		end else if (ctrl_caret) begin
			push_desc.ch = (c7 == tlnvf_pkg::CH_DEL) ? tlnvf_pkg::CH_QMARK :
				c7 + tlnvf_pkg::CH_CTRL_OFFSET;
		end else begin
			push_desc.ch = c7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tlnvf_pkg::CFG_NUMBER_ALL:       cfg_q.number_all <= cfg_data;
				tlnvf_pkg::CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank <= cfg_data;
				tlnvf_pkg::CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank <= cfg_data;
				tlnvf_pkg::CFG_SHOW_ENDS:        cfg_q.show_ends <= cfg_data;
				tlnvf_pkg::CFG_SHOW_TABS:        cfg_q.show_tabs <= cfg_data;
				tlnvf_pkg::CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_nl_q <= 1'b1;
			blank_run_q <= 2'd0;
			bcd_q <= '0;
		end else if (accept) begin
			blank_run_q <= blank_run_next;
			// a squeezed newline leaves the line state alone
			if (!drop) begin
				after_nl_q <= is_nl;
				if (numb) begin
					bcd_q <= bcd_inc;
				end
			end
		end
	end

endmodule

// ----- src/tlnvf_queue.sv -----
`timescale 1ns / 1ps

module tlnvf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tlnvf_pkg::item_desc_t push_desc,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output tlnvf_pkg::item_desc_t head_desc
);

	tlnvf_pkg::item_desc_t mem_q [tlnvf_pkg::QUEUE_DEPTH];
	tlnvf_pkg::qptr_t wr_ptr_q;
	tlnvf_pkg::qptr_t rd_ptr_q;
	tlnvf_pkg::qcnt_t count_q;

	logic do_pop;

	assign full = (count_q == tlnvf_pkg::QCNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_desc = mem_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == tlnvf_pkg::QPTR_MAX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == tlnvf_pkg::QPTR_MAX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/tlnvf_back.sv -----
`timescale 1ns / 1ps

module tlnvf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  tlnvf_pkg::item_desc_t head_desc,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            byte_out,
	output logic                  last
);

	tlnvf_pkg::phase_t phase_q;
	tlnvf_pkg::phase_t phase_next;
	tlnvf_pkg::phase_t eff_phase;
	tlnvf_pkg::phase_t after_num;
	tlnvf_pkg::dig_idx_t dig_q;
	tlnvf_pkg::dig_idx_t dig_next;
	tlnvf_pkg::dig_idx_t eff_idx;

	logic out_valid_q;
	logic [7:0] byte_q;
	logic last_q;

	logic emit;
	logic [3:0] digit;
	logic shown;
	logic [7:0] emit_byte;

	// leading zero digits print as blanks, the units digit always prints
	function automatic logic digit_shown(
		input logic [tlnvf_pkg::BCD_W-1:0] bcd,
		input tlnvf_pkg::dig_idx_t idx
	);
		logic s;
		s = (idx == '0);
		for (int i = 0; i < tlnvf_pkg::NUMBER_DIGITS; i++) begin
			if ((tlnvf_pkg::dig_idx_t'(i) >= idx) && (bcd[4*i +: 4] != 4'd0)) begin
				s = 1'b1;
			end
		end
		return s;
	endfunction

	assign emit = head_valid && (!out_valid_q || out_ready);
	assign pop = emit && (eff_phase == tlnvf_pkg::PH_CHAR);

	always_comb begin
		if (head_desc.dollar) begin
			after_num = tlnvf_pkg::PH_DOLLAR;
		end else if (head_desc.meta) begin
			after_num = tlnvf_pkg::PH_META;
		end else if (head_desc.caret) begin
			after_num = tlnvf_pkg::PH_CARET;
		end else begin
			after_num = tlnvf_pkg::PH_CHAR;
		end
		eff_phase = (phase_q == tlnvf_pkg::PH_START) ?
			(head_desc.number ? tlnvf_pkg::PH_DIGIT : after_num) : phase_q;
		eff_idx = (phase_q == tlnvf_pkg::PH_DIGIT) ? dig_q : tlnvf_pkg::DIG_MAX;
	end

	// next state
	always_comb begin
		phase_next = phase_q;
		dig_next = dig_q;
		if (emit) begin
			unique case (eff_phase)
				tlnvf_pkg::PH_DIGIT: begin
					if (eff_idx == '0) begin
						phase_next = tlnvf_pkg::PH_TAB;
					end else begin
						phase_next = tlnvf_pkg::PH_DIGIT;
						dig_next = eff_idx - 1'b1;
					end
				end
				tlnvf_pkg::PH_TAB:    phase_next = after_num;
				tlnvf_pkg::PH_DOLLAR: phase_next = tlnvf_pkg::PH_CHAR;
				tlnvf_pkg::PH_META:   phase_next = tlnvf_pkg::PH_DASH;
				tlnvf_pkg::PH_DASH:
					phase_next = head_desc.caret ? tlnvf_pkg::PH_CARET : tlnvf_pkg::PH_CHAR;
				tlnvf_pkg::PH_CARET:  phase_next = tlnvf_pkg::PH_CHAR;
				tlnvf_pkg::PH_CHAR:   phase_next = tlnvf_pkg::PH_START;
				default:              phase_next = tlnvf_pkg::PH_START;
			endcase
		end
	end

	// outputs
	always_comb begin
		digit = head_desc.bcd[4*eff_idx +: 4];
		shown = digit_shown(head_desc.bcd, eff_idx);
		unique case (eff_phase)
			tlnvf_pkg::PH_DIGIT:
				emit_byte = shown ? (tlnvf_pkg::CH_ZERO | {4'd0, digit}) : tlnvf_pkg::CH_SPACE;
			tlnvf_pkg::PH_TAB:    emit_byte = tlnvf_pkg::CH_TAB;
			tlnvf_pkg::PH_DOLLAR: emit_byte = tlnvf_pkg::CH_DOLLAR;
			tlnvf_pkg::PH_META:   emit_byte = tlnvf_pkg::CH_UPPER_M;
			tlnvf_pkg::PH_DASH:   emit_byte = tlnvf_pkg::CH_DASH;
			tlnvf_pkg::PH_CARET:  emit_byte = tlnvf_pkg::CH_CARET;
			default:              emit_byte = head_desc.ch;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tlnvf_pkg::PH_START;
			dig_q <= '0;
		end else begin
			phase_q <= phase_next;
			dig_q <= dig_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= emit_byte;
			last_q <= (eff_phase == tlnvf_pkg::PH_CHAR);
		end
	end

	assign out_valid = out_valid_q;
	assign byte_out = byte_q;
	assign last = last_q;

endmodule

// ----- src/text_line_number_visible_filter.sv -----
`timescale 1ns / 1ps
// path: an accepted request is registered in the queue, and its first output byte then in the output register
// throughput: one output byte per cycle from the expansion sequencer while the output is not stalled;
// a request holds it until its last output byte is emitted, so plain bytes flow at one request per cycle
// a two-entry queue between classifier and sequencer absorbs expansions and stalls
// reset (arst_n low): options off, start of line, blank run zero, line count zero

module text_line_number_visible_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  tlnvf_pkg::cfg_idx_t cfg_index,
	input  logic                cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          byte_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          byte_out,
	output logic                last
);

	logic q_full;
	logic push;
	logic pop;
	logic head_valid;
	tlnvf_pkg::item_desc_t push_desc;
	tlnvf_pkg::item_desc_t head_desc;

	tlnvf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.byte_in   (byte_in),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	tlnvf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	tlnvf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_out   (byte_out),
		.last       (last)
	);

endmodule
